// ----- src/blm_pkg.sv -----
// shared types, constants and curve tables for the battery level monitor
`timescale 1ns / 1ps

package blm_pkg;

  // held level state
  typedef enum logic [2:0] {
    LVL_UNKNOWN  = 3'd0,
    LVL_CRITICAL = 3'd1,
    LVL_LOW      = 3'd2,
    LVL_OK       = 3'd3,
    LVL_FULL     = 3'd4
  } level_t;

  // warning message codes
  typedef enum logic [1:0] {
    MSG_CRITICAL    = 2'd0,
    MSG_LOW         = 2'd1,
    MSG_GETTING_LOW = 2'd2,
    MSG_OK          = 2'd3
  } msg_t;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_CRITICAL = 3'd1;
  localparam logic [2:0] REG_LOW      = 3'd2;
  localparam logic [2:0] REG_FULL     = 3'd3;
  localparam logic [2:0] REG_WARNING  = 3'd4;
  localparam logic [2:0] REG_HYST     = 3'd5;
  localparam logic [2:0] REG_INTERVAL = 3'd6;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  // configuration register contents
  typedef struct packed {
    logic        enable;
    logic [15:0] critical_mv;
    logic [15:0] low_mv;
    logic [15:0] full_mv;
    logic [15:0] warning_mv;
    logic [15:0] hysteresis_mv;
    logic [15:0] interval_ms;
  } cfg_t;

  // discharge curve, highest voltage first
  localparam int CurvePoints = 11;
  localparam logic [12:0] CURVE_MV [CurvePoints] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3700,
    13'd3600, 13'd3500, 13'd3400, 13'd3300, 13'd3200
  };
  localparam logic [6:0] CURVE_PCT [CurvePoints] = '{
    7'd100, 7'd95, 7'd88, 7'd78, 7'd65, 7'd50,
    7'd35, 7'd22, 7'd12, 7'd5, 7'd0
  };

  // every curve segment spans 100 mV; x/100 == (x*1311)>>17 for x below 1600
  localparam logic [10:0] RECIP_100   = 11'd1311;
  localparam int          RecipShift  = 17;

  localparam logic [6:0] CHANGE_STEP = 7'd2;

endpackage

// ----- src/battery_level_monitor.sv -----
// top level of the battery level monitor
`timescale 1ns / 1ps

// battery level monitor: each input transaction is one reading and gives
// exactly one result transaction. a reading is held in an input register,
// evaluated combinationally against the held state (sample interval check,
// curve lookup, level hysteresis, change detection) and written to the result
// register, while the held state updates on the same edge. one reading can
// be accepted every clock cycle while no result is stalled; a reading passes
// the input register and then the result register. the rate is set by the
// loop through the held state, which the next reading sees once it is
// registered. a result that waits on out_ready holds the pipe: the input
// register still takes one more reading. configuration writes land at once
// and are meant for idle periods only. the state of charge uses an 11-point
// lipo curve with truncating interpolation; the level rises out of critical
// or low only once the voltage clears the threshold by hysteresis_mv.

module battery_level_monitor (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [blm_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [blm_pkg::CfgDataW-1:0]  cfg_wdata,
  // reading channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   now_ms,
  input  logic [15:0]                   battery_mv,
  input  logic [15:0]                   supply_mv,
  input  logic                          ext_power,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          sampled,
  output logic                          changed,
  output logic [2:0]                    level_state,
  output logic [6:0]                    percent,
  output logic [15:0]                   held_battery_mv,
  output logic [15:0]                   held_supply_mv,
  output logic                          charging,
  output logic                          is_critical,
  output logic                          safe_to_arm,
  output logic                          warning,
  output logic [1:0]                    message_code
);
  import blm_pkg::*;

  cfg_t cfg;

  // input register
  logic        stage_valid;
  logic [31:0] stage_now;
  logic [15:0] stage_bat;
  logic [15:0] stage_sup;
  logic        stage_ext;

  // held state
  logic [15:0] held_mv;
  logic [15:0] held_supply;
  logic [6:0]  held_percent;
  level_t      level_code;
  logic [31:0] last_sample_time;

  // next values
  logic [15:0] held_mv_next;
  logic [15:0] held_supply_next;
  logic [6:0]  held_percent_next;
  level_t      level_code_next;
  logic [31:0] last_sample_time_next;

  logic        advance;
  logic [31:0] elapsed;
  logic        take;
  logic        good;
  level_t      new_level;
  logic [6:0]  new_pct;
  logic [6:0]  pct_delta;
  logic        changed_next;
  logic        at_warning;
  msg_t        msg_next;

  blm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  blm_soc u_soc (
    .mv  (stage_bat),
    .pct (new_pct)
  );

  blm_level u_level (
    .mv        (stage_bat),
    .cur_level (level_code),
    .cfg       (cfg),
    .new_level (new_level)
  );

  // the evaluated reading moves on when the result register is free or drains
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // sample gate: interval passed, or never sampled (time zero counts as never)
  assign elapsed = stage_now - last_sample_time;
  assign take    = cfg.enable &&
                   !(elapsed < {16'd0, cfg.interval_ms} && last_sample_time != 32'd0);
  assign good    = take && (stage_bat != 16'd0);

  assign pct_delta = (new_pct > held_percent) ? new_pct - held_percent
                                              : held_percent - new_pct;
  assign changed_next = good && (new_level != level_code || pct_delta >= CHANGE_STEP);

  // a bad read still moves the sample time on
  assign last_sample_time_next = take ? stage_now : last_sample_time;
  assign held_mv_next          = good ? stage_bat : held_mv;
  assign held_supply_next      = good ? stage_sup : held_supply;
  assign held_percent_next     = good ? new_pct   : held_percent;
  assign level_code_next       = good ? new_level : level_code;

  assign at_warning = held_mv_next <= cfg.warning_mv;

  always_comb begin
    priority if (level_code_next == LVL_CRITICAL) begin
      msg_next = MSG_CRITICAL;
    end else if (level_code_next == LVL_LOW) begin
      msg_next = MSG_LOW;
    end else if (at_warning) begin
      msg_next = MSG_GETTING_LOW;
    end else begin
      msg_next = MSG_OK;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_now <= now_ms;
      stage_bat <= battery_mv;
      stage_sup <= supply_mv;
      stage_ext <= ext_power;
    end
  end

  // held state, updated as each reading leaves the evaluation stage
  always_ff @(posedge clk) begin
    if (rst) begin
      held_mv          <= '0;
      held_supply      <= '0;
      held_percent     <= '0;
      level_code       <= LVL_UNKNOWN;
      last_sample_time <= '0;
    end else if (advance) begin
      held_mv          <= held_mv_next;
      held_supply      <= held_supply_next;
      held_percent     <= held_percent_next;
      level_code       <= level_code_next;
      last_sample_time <= last_sample_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      sampled         <= good;
      changed         <= changed_next;
      level_state     <= level_code_next;
      percent         <= held_percent_next;
      held_battery_mv <= held_mv_next;
      held_supply_mv  <= held_supply_next;
      charging        <= stage_ext && (level_code_next != LVL_FULL);
      is_critical     <= level_code_next == LVL_CRITICAL;
      safe_to_arm     <= stage_ext || level_code_next == LVL_OK ||
                         level_code_next == LVL_FULL;
      warning         <= !stage_ext && (held_mv_next != 16'd0) && at_warning;
      message_code    <= msg_next;
    end
  end

endmodule

// ----- src/blm_cfg_regs.sv -----
// configuration register file of the battery level monitor
`timescale 1ns / 1ps

module blm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [blm_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [blm_pkg::CfgDataW-1:0]  cfg_wdata,
  output blm_pkg::cfg_t                 cfg
);
  import blm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b0;
      cfg.critical_mv   <= 16'd3300;
      cfg.low_mv        <= 16'd3500;
      cfg.full_mv       <= 16'd4100;
      cfg.warning_mv    <= 16'd3700;
      cfg.hysteresis_mv <= 16'd100;
      cfg.interval_ms   <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:   cfg.enable        <= cfg_wdata[0];
        REG_CRITICAL: cfg.critical_mv   <= cfg_wdata;
        REG_LOW:      cfg.low_mv        <= cfg_wdata;
        REG_FULL:     cfg.full_mv       <= cfg_wdata;
        REG_WARNING:  cfg.warning_mv    <= cfg_wdata;
        REG_HYST:     cfg.hysteresis_mv <= cfg_wdata;
        REG_INTERVAL: cfg.interval_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/blm_soc.sv -----
// state of charge from the interpolated discharge curve
`timescale 1ns / 1ps

module blm_soc (
  input  logic [15:0] mv,
  output logic [6:0]  pct
);
  import blm_pkg::*;

  logic [6:0]  seg_lo_pct;
  logic [3:0]  seg_span;
  logic [6:0]  seg_off;
  logic [10:0] prod;
  logic [21:0] scaled;
  logic [6:0]  frac;

  // pick the segment with lo < mv <= hi
  always_comb begin
    seg_lo_pct = '0;
    seg_span   = '0;
    seg_off    = '0;
    for (int k = 0; k < CurvePoints - 1; k++) begin
      if (mv <= {3'b000, CURVE_MV[k]} && mv > {3'b000, CURVE_MV[k+1]}) begin
        seg_lo_pct = CURVE_PCT[k+1];
        seg_span   = 4'(CURVE_PCT[k] - CURVE_PCT[k+1]);
        seg_off    = 7'(mv - {3'b000, CURVE_MV[k+1]});
      end
    end
  end

  assign prod   = 11'(seg_off) * 11'(seg_span);
  assign scaled = 22'(prod) * 22'(RECIP_100);
  assign frac   = 7'(scaled >> RecipShift);

  always_comb begin
    priority if (mv >= {3'b000, CURVE_MV[0]}) begin
      pct = CURVE_PCT[0];
    end else if (mv <= {3'b000, CURVE_MV[CurvePoints-1]}) begin
      pct = CURVE_PCT[CurvePoints-1];
    end else begin
      pct = seg_lo_pct + frac;
    end
  end

endmodule

// ----- src/blm_level.sv -----
// level state decision with hysteresis on leaving critical or low
`timescale 1ns / 1ps

module blm_level (
  input  logic [15:0]     mv,
  input  blm_pkg::level_t cur_level,
  input  blm_pkg::cfg_t   cfg,
  output blm_pkg::level_t new_level
);
  import blm_pkg::*;

  logic [16:0] crit_exit;
  logic [16:0] low_exit;
  logic        below_crit;

  assign crit_exit  = {1'b0, cfg.critical_mv} + {1'b0, cfg.hysteresis_mv};
  assign low_exit   = {1'b0, cfg.low_mv} + {1'b0, cfg.hysteresis_mv};
  assign below_crit = mv < cfg.critical_mv;

  always_comb begin
    priority if (cur_level == LVL_CRITICAL && {1'b0, mv} <= crit_exit) begin
      new_level = LVL_CRITICAL;
    end else if (cur_level == LVL_LOW && {1'b0, mv} <= low_exit) begin
      new_level = below_crit ? LVL_CRITICAL : LVL_LOW;
    end else if (below_crit) begin
      new_level = LVL_CRITICAL;
    end else if (mv < cfg.low_mv) begin
      new_level = LVL_LOW;
    end else if (mv >= cfg.full_mv) begin
      new_level = LVL_FULL;
    end else begin
      new_level = LVL_OK;
    end
  end

endmodule

// ----- src/blm_checker.sv -----
// port-level checks for the battery level monitor, bound to the top level
`timescale 1ns / 1ps

module blm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        sampled,
  input logic        changed,
  input logic [2:0]  level_state,
  input logic [6:0]  percent,
  input logic [15:0] held_battery_mv,
  input logic [15:0] held_supply_mv,
  input logic        charging,
  input logic        is_critical,
  input logic        safe_to_arm,
  input logic        warning,
  input logic [1:0]  message_code
);
  import blm_pkg::*;

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level_state) &&
      $stable(percent) && $stable(held_battery_mv) && $stable(message_code) &&
      $stable(held_supply_mv) && $stable(warning))
    else $error("stalled result changed");

  // a change is only reported for a taken sample
  a_changed_sampled: assert property (@(posedge clk) disable iff (rst)
    out_valid && changed |-> sampled)
    else $error("changed without sampled");

  // critical flag and message agree with the level
  a_critical_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_critical == (level_state == LVL_CRITICAL)) &&
      ((message_code == MSG_CRITICAL) == is_critical))
    else $error("critical flags disagree with level");

  // a full battery is never charging and is always safe to arm
  a_full_not_charging: assert property (@(posedge clk) disable iff (rst)
    out_valid && level_state == LVL_FULL |-> !charging && safe_to_arm)
    else $error("full level flags wrong");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);

// ----- dv/testbench.sv -----
// self-checking testbench for the battery level monitor, with its scoreboard and predictor
`timescale 1ns / 1ps

import blm_pkg::*;

// one result transaction as seen on the result channel
typedef struct {
  logic        sampled;
  logic        changed;
  logic [2:0]  level;
  logic [6:0]  pct;
  logic [15:0] bat_mv;
  logic [15:0] sup_mv;
  logic        charging;
  logic        critical;
  logic        safe;
  logic        warning;
  logic [1:0]  msg;
} level_report_t;

class soc_scoreboard;
  // register copy, reset values
  bit        enable;
  bit [15:0] critical_mv = 16'd3300;
  bit [15:0] low_mv      = 16'd3500;
  bit [15:0] full_mv     = 16'd4100;
  bit [15:0] warning_mv  = 16'd3700;
  bit [15:0] hyst_mv     = 16'd100;
  bit [15:0] interval_ms = 16'd2000;
  // held state
  bit [15:0] held_mv;
  bit [15:0] held_sup;
  bit [6:0]  held_pct;
  level_t    level = LVL_UNKNOWN;
  bit [31:0] last_t;
  // lipo discharge curve, highest voltage first
  int knee_mv [11] = '{4200, 4100, 4000, 3900, 3800, 3700, 3600, 3500, 3400, 3300, 3200};
  int knee_pct [11] = '{100, 95, 88, 78, 65, 50, 35, 22, 12, 5, 0};

  level_report_t expected_q [$];
  int fails;
  int checked;

  function void set_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_ENABLE:   enable      = val[0];
      REG_CRITICAL: critical_mv = val;
      REG_LOW:      low_mv      = val;
      REG_FULL:     full_mv     = val;
      REG_WARNING:  warning_mv  = val;
      REG_HYST:     hyst_mv     = val;
      REG_INTERVAL: interval_ms = val;
      default: ;
    endcase
  endfunction

  function int charge_of(int mv);
    int k;
    if (mv >= knee_mv[0]) return 100;
    if (mv <= knee_mv[10]) return 0;
    for (k = 0; k < 10; k++) begin
      if (mv <= knee_mv[k] && mv > knee_mv[k+1])
        return knee_pct[k+1] + ((mv - knee_mv[k+1]) * (knee_pct[k] - knee_pct[k+1])) /
               (knee_mv[k] - knee_mv[k+1]);
    end
    return 0;
  endfunction

  function level_t level_for(int mv);
    int crit_top;
    int low_top;
    // threshold plus margin kept wide, no wrap
    crit_top = int'(critical_mv) + int'(hyst_mv);
    low_top  = int'(low_mv) + int'(hyst_mv);
    if (level == LVL_CRITICAL && mv <= crit_top) return LVL_CRITICAL;
    if (level == LVL_LOW && mv <= low_top)
      return (mv < int'(critical_mv)) ? LVL_CRITICAL : LVL_LOW;
    if (mv < int'(critical_mv)) return LVL_CRITICAL;
    if (mv < int'(low_mv)) return LVL_LOW;
    if (mv >= int'(full_mv)) return LVL_FULL;
    return LVL_OK;
  endfunction

  // accepted reading: advance the held state and queue the result it causes
  function void note_reading(bit [31:0] now, bit [15:0] bat, bit [15:0] sup, bit ext);
    level_report_t r;
    bit [31:0]     elapsed;
    level_t        nxt;
    int            np;
    int            dp;
    r.sampled = 1'b0;
    r.changed = 1'b0;
    if (enable) begin
      elapsed = now - last_t;
      if (!(elapsed < interval_ms && last_t != 0)) begin
        last_t = now;
        if (bat != 0) begin
          nxt = level_for(int'(bat));
          np  = charge_of(int'(bat));
          dp  = np - int'(held_pct);
          if (dp < 0) dp = -dp;
          r.changed = (nxt != level) || (dp >= int'(CHANGE_STEP));
          held_mv   = bat;
          held_sup  = sup;
          held_pct  = np[6:0];
          level     = nxt;
          r.sampled = 1'b1;
        end
      end
    end
    r.level    = level;
    r.pct      = held_pct;
    r.bat_mv   = held_mv;
    r.sup_mv   = held_sup;
    r.charging = ext && level != LVL_FULL;
    r.critical = level == LVL_CRITICAL;
    r.safe     = ext || level == LVL_OK || level == LVL_FULL;
    r.warning  = !ext && held_mv != 0 && held_mv <= warning_mv;
    if (level == LVL_CRITICAL) r.msg = MSG_CRITICAL;
    else if (level == LVL_LOW) r.msg = MSG_LOW;
    else r.msg = (held_mv <= warning_mv) ? MSG_GETTING_LOW : MSG_OK;
    expected_q.push_back(r);
  endfunction

  task report(string what);
    fails++;
    $display("mismatch: %s", what);
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
  endtask

  task check_result(level_report_t got);
    level_report_t want;
    if (expected_q.size() == 0) begin
      report("result transaction with no reading waiting");
      return;
    end
    want = expected_q.pop_front();
    compare_field("sampled", got.sampled, want.sampled);
    compare_field("changed", got.changed, want.changed);
    compare_field("level_state", got.level, want.level);
    compare_field("percent", got.pct, want.pct);
    compare_field("held_battery_mv", got.bat_mv, want.bat_mv);
    compare_field("held_supply_mv", got.sup_mv, want.sup_mv);
    compare_field("charging", got.charging, want.charging);
    compare_field("is_critical", got.critical, want.critical);
    compare_field("safe_to_arm", got.safe, want.safe);
    compare_field("warning", got.warning, want.warning);
    compare_field("message_code", got.msg, want.msg);
    checked++;
  endtask
endclass

module testbench;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 cfg_we     = 1'b0;
  logic [CfgIndexW-1:0] cfg_index  = '0;
  logic [CfgDataW-1:0]  cfg_wdata  = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [31:0]          now_ms     = '0;
  logic [15:0]          battery_mv = '0;
  logic [15:0]          supply_mv  = '0;
  logic                 ext_power  = 1'b0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic                 sampled;
  logic                 changed;
  logic [2:0]           level_state;
  logic [6:0]           percent;
  logic [15:0]          held_battery_mv;
  logic [15:0]          held_supply_mv;
  logic                 charging;
  logic                 is_critical;
  logic                 safe_to_arm;
  logic                 warning;
  logic [1:0]           message_code;

  battery_level_monitor dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .now_ms         (now_ms),
    .battery_mv     (battery_mv),
    .supply_mv      (supply_mv),
    .ext_power      (ext_power),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sampled        (sampled),
    .changed        (changed),
    .level_state    (level_state),
    .percent        (percent),
    .held_battery_mv(held_battery_mv),
    .held_supply_mv (held_supply_mv),
    .charging       (charging),
    .is_critical    (is_critical),
    .safe_to_arm    (safe_to_arm),
    .warning        (warning),
    .message_code   (message_code)
  );

  soc_scoreboard sb = new();

  // idling odds in percent, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // register values of the current setting, reset values to start with
  bit [15:0] cur_regs [7] = '{16'd0, 16'd3300, 16'd3500, 16'd4100, 16'd3700, 16'd100, 16'd2000};

  // generator state: running millisecond clock and a wandering battery voltage
  bit [31:0] clock_ms = 32'd0;
  int        walk_mv  = 3700;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(12 * 400000);
    $display("testbench: FAIL");
    $finish;
  end

  // result side: random back-pressure, and every accepted transaction checked
  // against the oldest prediction; values are sampled before this edge updates them
  always @(posedge clk) begin : result_monitor
    level_report_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.sampled  = sampled;
      got.changed  = changed;
      got.level    = level_state;
      got.pct      = percent;
      got.bat_mv   = held_battery_mv;
      got.sup_mv   = held_supply_mv;
      got.charging = charging;
      got.critical = is_critical;
      got.safe     = safe_to_arm;
      got.warning  = warning;
      got.msg      = message_code;
      sb.check_result(got);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one reading transaction: optional idle gap, then valid held until accepted
  task automatic send_reading(bit [31:0] now, bit [15:0] bat, bit [15:0] sup, bit ext);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    now_ms     <= now;
    battery_mv <= bat;
    supply_mv  <= sup;
    ext_power  <= ext;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    sb.note_reading(now, bat, sup, ext);
  endtask

  // lower valid and wait until every prediction has been matched, then let
  // the pipe run empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all seven registers back to back from cur_regs; only called when idle
  task automatic write_settings();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CfgIndexW-1:0];
      cfg_wdata <= cur_regs[i];
      @(posedge clk);
      sb.set_reg(i[2:0], cur_regs[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // register settings per phase, extremes and inconsistent orderings among them
  task automatic choose_settings(int kind);
    cur_regs = '{16'd1, 16'd3300, 16'd3500, 16'd4100, 16'd3700, 16'd100, 16'd2000};
    case (kind)
      1: begin
        // sample on every reading, thresholds around the curve
        cur_regs[REG_CRITICAL] = $urandom_range(3100, 3450);
        cur_regs[REG_LOW]      = $urandom_range(3400, 3700);
        cur_regs[REG_FULL]     = $urandom_range(3900, 4300);
        cur_regs[REG_WARNING]  = $urandom_range(3500, 3900);
        cur_regs[REG_HYST]     = $urandom_range(0, 300);
        cur_regs[REG_INTERVAL] = 16'd0;
      end
      2: begin
        // everything at the top; threshold plus margin needs the 17th bit
        for (int i = 1; i < 7; i++) cur_regs[i] = 16'hffff;
      end
      3: begin
        for (int i = 1; i < 7; i++) cur_regs[i] = 16'h0000;
      end
      4: begin
        // disabled: no reading is sampled and the held state stays as it was
        cur_regs[REG_ENABLE] = 16'd0;
        for (int i = 1; i < 7; i++) cur_regs[i] = $urandom_range(0, 65535);
      end
      5: begin
        // arbitrary values, thresholds in any order
        for (int i = 1; i < 6; i++) cur_regs[i] = $urandom_range(0, 65535);
        cur_regs[REG_INTERVAL] = $urandom_range(0, 65535);
      end
      6: cur_regs[REG_INTERVAL] = $urandom_range(0, 50);
      7: begin
        cur_regs[REG_CRITICAL] = $urandom_range(3000, 3800);
        cur_regs[REG_LOW]      = $urandom_range(3000, 3800);
        cur_regs[REG_FULL]     = $urandom_range(3600, 4400);
        cur_regs[REG_WARNING]  = $urandom_range(3000, 4200);
        cur_regs[REG_HYST]     = $urandom_range(0, 600);
        cur_regs[REG_INTERVAL] = $urandom_range(1, 5000);
      end
      default: ;
    endcase
  endtask

  // one random reading: time mostly steps past the interval so most are sampled,
  // voltage mostly wanders across the curve or sits at a threshold edge
  task automatic random_reading();
    int        sel;
    int        base;
    bit [15:0] bat;
    sel = $urandom_range(0, 99);
    if (sel < 75) clock_ms += cur_regs[REG_INTERVAL] + $urandom_range(0, 30);
    else if (sel < 88) clock_ms += $urandom_range(0, cur_regs[REG_INTERVAL]);
    else if (sel < 94) clock_ms = $urandom();
    else if (sel < 97) clock_ms = 32'd0;
    else clock_ms += $urandom_range(0, 3);

    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      bat = 16'd0;
    end else if (sel < 18) begin
      bat = $urandom_range(0, 65535);
    end else if (sel < 33) begin
      case ($urandom_range(0, 6))
        0: base = cur_regs[REG_CRITICAL];
        1: base = cur_regs[REG_LOW];
        2: base = cur_regs[REG_FULL];
        3: base = cur_regs[REG_WARNING];
        4: base = int'(cur_regs[REG_CRITICAL]) + int'(cur_regs[REG_HYST]);
        5: base = int'(cur_regs[REG_LOW]) + int'(cur_regs[REG_HYST]);
        default: base = 3200 + 100 * $urandom_range(0, 10);
      endcase
      base = base + $urandom_range(0, 4) - 2;
      if (base < 0) base = 0;
      if (base > 65535) base = 65535;
      bat = base[15:0];
    end else begin
      walk_mv = walk_mv + $urandom_range(0, 300) - 150;
      if (walk_mv < 2900) walk_mv = 2900;
      if (walk_mv > 4500) walk_mv = 4500;
      bat = walk_mv[15:0];
    end
    send_reading(clock_ms, bat, $urandom_range(0, 65535), $urandom_range(0, 1));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset: held values stay zero
    send_reading(32'd5000, 16'd3900, 16'd5000, 1'b0);
    send_reading(32'hffff_ffff, 16'hffff, 16'hffff, 1'b1);
    settle();

    // reset thresholds, monitor enabled
    choose_settings(0);
    write_settings();
    send_reading(32'd5000, 16'd4200, 16'd5100, 1'b0);   // first sample, full
    send_reading(32'd5001, 16'd3000, 16'd0, 1'b1);      // interval not yet elapsed
    send_reading(32'd7001, 16'd0, 16'd4000, 1'b0);      // bad read, time still kept
    send_reading(32'd8000, 16'd3000, 16'd4000, 1'b0);   // too soon after the bad read
    send_reading(32'd9001, 16'd3250, 16'd4000, 1'b0);   // critical
    send_reading(32'd11001, 16'd3400, 16'd4000, 1'b1);  // still inside critical margin
    send_reading(32'd13001, 16'd3401, 16'd4000, 1'b0);  // clears critical, lands in low
    send_reading(32'd15001, 16'd3600, 16'd4000, 1'b0);  // still inside low margin
    send_reading(32'd17001, 16'd3299, 16'd4000, 1'b1);  // low drops to critical
    send_reading(32'd19001, 16'd3750, 16'd4000, 1'b0);  // clears critical straight to ok
    send_reading(32'd21001, 16'd4100, 16'd4000, 1'b1);  // full at the threshold
    send_reading(32'd23001, 16'd4099, 16'd4000, 1'b0);  // just under full
    send_reading(32'd25001, 16'hffff, 16'hffff, 1'b0);  // top of range
    send_reading(32'd27001, 16'd1, 16'd1, 1'b1);        // bottom of range
    send_reading(32'd0, 16'd3650, 16'd4000, 1'b0);      // sample at time zero
    send_reading(32'd1, 16'd3555, 16'd4000, 1'b0);      // counts as never sampled
    send_reading(32'hffff_ff00, 16'd3820, 16'd4000, 1'b1);
    send_reading(32'h0000_0500, 16'd3820, 16'd4000, 1'b1); // wrapped, too soon
    send_reading(32'h0000_0900, 16'd3905, 16'd4000, 1'b0); // wrapped, elapsed
    send_reading(32'h0000_1200, 16'd3705, 16'd4000, 1'b0); // between curve points
    settle();

    // random phases, each with its own setting and idling mix
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      choose_settings(phase);
      write_settings();
      walk_mv = $urandom_range(3000, 4400);
      repeat (72) random_reading();
      settle();
    end

    // pipe empty: wait a little longer for any stray transaction
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.report("readings left without a result");
    if (sb.fails == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
